// ----- src/sbct_pkg.sv -----
// ----------------------------------------------------------------------------
// sbct_pkg
// shared types and constants for the swept box collision time core
// ----------------------------------------------------------------------------
package sbct_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int COORD_W    = 32;
   localparam int SIZE_W     = 24;
   localparam int BIAS_W     = 16;
   localparam int QUO_W      = FRAC_BITS + 1;
   localparam int TIME_W     = FRAC_BITS + 2;
   localparam int DIV_STAGES = FRAC_BITS + 1;
   localparam int REQ_DATA_W = 7 * COORD_W;
   localparam int RSP_DATA_W = ((TIME_W + 7) / 8) * 8;
   localparam int CSR_ADDR_W = 5;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2,
      AXIS_NONE = 2'd3
   } axis_type;

   typedef enum logic [2:0] {
      REG_MOVER_WIDTH  = 3'd0,
      REG_MOVER_HEIGHT = 3'd1,
      REG_MOVER_LENGTH = 3'd2,
      REG_BLOCK_WIDTH  = 3'd3,
      REG_BLOCK_HEIGHT = 3'd4,
      REG_BLOCK_LENGTH = 3'd5,
      REG_TIME_BIAS    = 3'd6,
      REG_UNUSED       = 3'd7
   } reg_index_type;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(65536);
   localparam logic [BIAS_W-1:0] BIAS_RESET = BIAS_W'(66);

   typedef struct packed {
      logic [2:0][SIZE_W-1:0] mover_size;
      logic [2:0][SIZE_W-1:0] static_size;
      logic [BIAS_W-1:0]      time_bias;
   } cfg_type;

   typedef struct packed {
      logic               cand;
      logic [COORD_W-1:0] gap_mag;
      logic [COORD_W-1:0] vel_mag;
   } job_type;

endpackage

// ----- src/swept_box_collision_time_core.sv -----
// ----------------------------------------------------------------------------
// swept_box_collision_time_core
// swept box contact time along one axis in q2.16, streaming in and out
// ----------------------------------------------------------------------------
// One box pair is taken every clock cycle while the queue has room, and one
// result comes out for each, in order. A request passes the classifier that
// measures the gap and tests the two side axes, then the job queue, then 17
// stages of the divider pipeline (one quotient bit per stage) and the result
// register. A four-entry job queue sits between the classifier and the
// divider, so that a stall on the result side only stops new requests once
// the queue has filled. The user must write the registers over the csr port
// only while no transaction is in flight; the block does not enforce this.
module swept_box_collision_time_core
   import sbct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // mover_x, mover_y, mover_z, block_x, block_y, block_z, velocity
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // collision_time
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // hit
   output logic                  rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type           cfg;
   logic              front_valid;
   logic              fifo_full;
   logic              fifo_empty;
   logic              fifo_pop;
   job_type           front_job;
   job_type           head_job;
   logic [TIME_W-1:0] rsp_time;

   sbct_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   sbct_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .in_axis   (req_tuser),
      .cfg       (cfg),
      .job_valid (front_valid),
      .job_ready (!fifo_full),
      .job       (front_job)
   );

   sbct_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (front_valid),
      .push_job (front_job),
      .full     (fifo_full),
      .pop      (fifo_pop),
      .empty    (fifo_empty),
      .head     (head_job)
   );

   sbct_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .job_avail (!fifo_empty),
      .job_take  (fifo_pop),
      .job       (head_job),
      .time_bias (cfg.time_bias),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hit   (rsp_tuser),
      .out_time  (rsp_time)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_time);

endmodule

// ----- src/sbct_csr.sv -----
// ----------------------------------------------------------------------------
// sbct_csr
// register file for box sizes and time bias behind an apb-style port
// ----------------------------------------------------------------------------
module sbct_csr
   import sbct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   reg_index_type idx;

   assign idx    = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mover_size  <= {3{SIZE_RESET}};
         cfg_ff.static_size <= {3{SIZE_RESET}};
         cfg_ff.time_bias   <= BIAS_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (idx)
            REG_MOVER_WIDTH:  cfg_ff.mover_size[0]  <= pwdata[SIZE_W-1:0];
            REG_MOVER_HEIGHT: cfg_ff.mover_size[1]  <= pwdata[SIZE_W-1:0];
            REG_MOVER_LENGTH: cfg_ff.mover_size[2]  <= pwdata[SIZE_W-1:0];
            REG_BLOCK_WIDTH:  cfg_ff.static_size[0] <= pwdata[SIZE_W-1:0];
            REG_BLOCK_HEIGHT: cfg_ff.static_size[1] <= pwdata[SIZE_W-1:0];
            REG_BLOCK_LENGTH: cfg_ff.static_size[2] <= pwdata[SIZE_W-1:0];
            REG_TIME_BIAS:    cfg_ff.time_bias      <= pwdata[BIAS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_MOVER_WIDTH:  prdata = 32'(cfg_ff.mover_size[0]);
         REG_MOVER_HEIGHT: prdata = 32'(cfg_ff.mover_size[1]);
         REG_MOVER_LENGTH: prdata = 32'(cfg_ff.mover_size[2]);
         REG_BLOCK_WIDTH:  prdata = 32'(cfg_ff.static_size[0]);
         REG_BLOCK_HEIGHT: prdata = 32'(cfg_ff.static_size[1]);
         REG_BLOCK_LENGTH: prdata = 32'(cfg_ff.static_size[2]);
         REG_TIME_BIAS:    prdata = 32'(cfg_ff.time_bias);
         default:          prdata = 32'd0;
      endcase
   end

endmodule

// ----- src/sbct_front.sv -----
// ----------------------------------------------------------------------------
// sbct_front
// accepts box pairs, measures the gap and checks window and side overlap
// ----------------------------------------------------------------------------
module sbct_front
   import sbct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [REQ_DATA_W-1:0] in_data,
   input  logic [1:0]            in_axis,
   input  cfg_type               cfg,
   output logic                  job_valid,
   input  logic                  job_ready,
   output job_type               job
);

   localparam int W = COORD_W + 2;

   logic    valid_ff;
   job_type job_ff;
   job_type job_in;

   function automatic logic signed [W-1:0] ext_c(input logic [COORD_W-1:0] v);
      ext_c = W'($signed(v));
   endfunction

   function automatic logic signed [W-1:0] ext_s(input logic [SIZE_W-1:0] v);
      ext_s = $signed(W'(v));
   endfunction

   function automatic logic apart(input logic [COORD_W-1:0] m,
                                  input logic [SIZE_W-1:0]  ms,
                                  input logic [COORD_W-1:0] s,
                                  input logic [SIZE_W-1:0]  ss,
                                  input logic [SIZE_W-1:0]  tol,
                                  input logic               mover_inside);
      logic signed [W-1:0] mm, sm, mt, st, d1, d2, t;
      logic contained, far1, far2;
      mm = ext_c(m);
      sm = ext_c(s);
      mt = mm + ext_s(ms);
      st = sm + ext_s(ss);
      t  = ext_s(tol);
      d1 = sm - mm;
      d2 = st - mt;
      far1 = (d1 >= t) || (d1 <= -t);
      far2 = (d2 >= t) || (d2 <= -t);
      contained = mover_inside ? (mm > sm && mt < st) : (sm > mm && st < mt);
      apart = far1 && far2 && !contained;
   endfunction

   always_comb begin
      logic [2:0][COORD_W-1:0] m, s;
      logic [COORD_W-1:0]      v, ma, sa;
      logic [SIZE_W-1:0]       msz, ssz;
      logic signed [W-1:0]     vs, gap;
      logic                    pos, window, blocked, axis_ok;
      m[0] = in_data[0*COORD_W +: COORD_W];
      m[1] = in_data[1*COORD_W +: COORD_W];
      m[2] = in_data[2*COORD_W +: COORD_W];
      s[0] = in_data[3*COORD_W +: COORD_W];
      s[1] = in_data[4*COORD_W +: COORD_W];
      s[2] = in_data[5*COORD_W +: COORD_W];
      v    = in_data[6*COORD_W +: COORD_W];
      vs   = ext_c(v);
      pos  = !v[COORD_W-1] && (v != '0);
      ma = m[0];
      sa = s[0];
      msz = cfg.mover_size[0];
      ssz = cfg.static_size[0];
      blocked = 1'b0;
      axis_ok = 1'b1;
      unique case (axis_type'(in_axis))
         AXIS_X: begin
            ma = m[0];
            sa = s[0];
            msz = cfg.mover_size[0];
            ssz = cfg.static_size[0];
            blocked = apart(m[2], cfg.mover_size[2], s[2], cfg.static_size[2],
                            cfg.mover_size[2], 1'b1)
                   || apart(m[1], cfg.mover_size[1], s[1], cfg.static_size[1],
                            cfg.static_size[1], 1'b0);
         end
         AXIS_Y: begin
            ma = m[1];
            sa = s[1];
            msz = cfg.mover_size[1];
            ssz = cfg.static_size[1];
            blocked = apart(m[0], cfg.mover_size[0], s[0], cfg.static_size[0],
                            cfg.mover_size[0], 1'b1)
                   || apart(m[2], cfg.mover_size[2], s[2], cfg.static_size[2],
                            cfg.mover_size[2], 1'b1);
         end
         AXIS_Z: begin
            ma = m[2];
            sa = s[2];
            msz = cfg.mover_size[2];
            ssz = cfg.static_size[2];
            blocked = apart(m[0], cfg.mover_size[0], s[0], cfg.static_size[0],
                            cfg.mover_size[0], 1'b1)
                   || apart(m[1], cfg.mover_size[1], s[1], cfg.static_size[1],
                            cfg.static_size[1], 1'b0);
         end
         default: axis_ok = 1'b0;
      endcase
      if (pos) begin
         gap    = ext_c(sa) - (ext_c(ma) + ext_s(msz));
         window = !gap[W-1] && (gap <= vs);
      end else begin
         gap    = (ext_c(sa) + ext_s(ssz)) - ext_c(ma);
         window = (gap <= 0) && (gap >= vs);
      end
      job_in.cand    = axis_ok && (v != '0) && window && !blocked;
      job_in.gap_mag = gap[W-1] ? COORD_W'(-gap) : gap[COORD_W-1:0];
      job_in.vel_mag = v[COORD_W-1] ? (~v + 1'b1) : v;
   end

   assign in_ready  = !valid_ff || job_ready;
   assign job_valid = valid_ff;
   assign job       = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         valid_ff <= 1'b1;
      end else if (job_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         job_ff <= job_in;
      end
   end

endmodule

// ----- src/sbct_fifo.sv -----
// ----------------------------------------------------------------------------
// sbct_fifo
// short job queue between the classifier and the divider pipeline
// ----------------------------------------------------------------------------
module sbct_fifo
   import sbct_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type head
);

   job_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff;
   logic [FIFO_PTR_W:0]     count_ff;
   logic                    do_push;
   logic                    do_pop;

   assign full    = (count_ff == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- src/sbct_divider.sv -----
// ----------------------------------------------------------------------------
// sbct_divider
// pipelined restoring divider, one quotient bit per stage, and result register
// ----------------------------------------------------------------------------
module sbct_divider
   import sbct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_avail,
   output logic                  job_take,
   input  job_type               job,
   input  logic [BIAS_W-1:0]     time_bias,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic                  out_hit,
   output logic [TIME_W-1:0]     out_time
);

   localparam int LAST = DIV_STAGES - 1;

   logic                 vld_ff  [DIV_STAGES];
   logic                 cand_ff [DIV_STAGES];
   logic [COORD_W-1:0]   den_ff  [DIV_STAGES];
   logic [COORD_W-1:0]   rem_ff  [DIV_STAGES];
   logic [QUO_W-1:0]     quo_ff  [DIV_STAGES];
   logic [COORD_W-1:0]   rem_in  [DIV_STAGES];
   logic [QUO_W-1:0]     quo_in  [DIV_STAGES];

   logic                         advance;
   logic                         rsp_valid_ff;
   logic                         rsp_hit_ff;
   logic [TIME_W-1:0]            rsp_time_ff;
   logic [TIME_W-1:0]            time_in;
   logic [FRAC_BITS+BIAS_W-1:0]  bias_wide;
   logic [FRAC_BITS-1:0]         bias_scaled;

   assign advance  = !rsp_valid_ff || out_ready;
   assign job_take = advance && job_avail;

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      if (k == 0) begin : g_first
         always_comb begin
            logic [COORD_W:0] trial;
            logic             take;
            trial = {1'b0, job.gap_mag};
            take  = trial >= {1'b0, job.vel_mag};
            rem_in[k] = take ? COORD_W'(trial - {1'b0, job.vel_mag})
                             : trial[COORD_W-1:0];
            quo_in[k] = QUO_W'(take);
         end
      end else begin : g_next
         always_comb begin
            logic [COORD_W:0] trial;
            logic             take;
            trial = {rem_ff[k-1], 1'b0};
            take  = trial >= {1'b0, den_ff[k-1]};
            rem_in[k] = take ? COORD_W'(trial - {1'b0, den_ff[k-1]})
                             : trial[COORD_W-1:0];
            quo_in[k] = {quo_ff[k-1][QUO_W-2:0], take};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= job_avail;
         for (int k = 1; k < DIV_STAGES; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cand_ff[0] <= job.cand;
         den_ff[0]  <= job.vel_mag;
         for (int k = 1; k < DIV_STAGES; k++) begin
            cand_ff[k] <= cand_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
         end
         for (int k = 0; k < DIV_STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   // bias is q0.16, rescaled to the fraction width
   assign bias_wide   = {time_bias, {FRAC_BITS{1'b0}}};
   assign bias_scaled = bias_wide[FRAC_BITS+BIAS_W-1:BIAS_W];

   always_comb begin
      if (cand_ff[LAST]) begin
         time_in = {1'b0, quo_ff[LAST]} - {2'b00, bias_scaled};
      end else begin
         time_in = TIME_W'(1) << FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff  <= cand_ff[LAST];
         rsp_time_ff <= time_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_hit   = rsp_hit_ff;
   assign out_time  = rsp_time_ff;

endmodule
